// File: rtl/spssr_pkg.sv
// ----------------------------------------------------------------------------
// spssr_pkg
// shared widths, reset values, register indexes and types of the soft-start
// ramp unit
// ----------------------------------------------------------------------------
package spssr_pkg;

    localparam int LEVEL_W  = 8;
    localparam int COUNT_W  = 16;
    localparam int STEP_W   = 5;
    localparam int CH_COUNT = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] TICK_LIMIT_RST      = 16'd500;
    localparam logic [LEVEL_W-1:0] STAGE_THRESHOLD_RST = 8'h40;
    localparam logic [LEVEL_W-1:0] FAST_FLOOR_RST      = 8'h23;
    localparam logic [STEP_W-1:0]  FAST_STEP_RST       = 5'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_RST           = 8'h90;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX           = 8'hff;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LIMIT      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_THRESHOLD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_FLOOR      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP       = 8'd3;

    // input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_DIR  = 1'b1;

    typedef logic [CH_COUNT-1:0][LEVEL_W-1:0] t_levels;

    typedef struct packed {
        logic [LEVEL_W-1:0] stage_threshold;
        logic [LEVEL_W-1:0] fast_floor;
        logic [STEP_W-1:0]  fast_step;
    } t_ramp_cfg;

endpackage

// File: rtl/spssr_if.sv
// ----------------------------------------------------------------------------
// spssr_if
// handshake channels of the soft-start ramp unit: input items, result words
// and configuration writes
// ----------------------------------------------------------------------------
interface spssr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] dir_byte;

    modport source (output valid, output cmd, output dir_byte, input ready);
    modport sink   (input valid, input cmd, input dir_byte, output ready);
endinterface

interface spssr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] level_ch0;
    logic [7:0] level_ch1;
    logic [7:0] level_ch2;
    logic [7:0] level_ch3;
    logic       stepped;
    logic       ramp_up;

    modport source (output valid, output level_ch0, output level_ch1, output level_ch2,
                    output level_ch3, output stepped, output ramp_up, input ready);
    modport sink   (input valid, input level_ch0, input level_ch1, input level_ch2,
                    input level_ch3, input stepped, input ramp_up, output ready);
endinterface

interface spssr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/spssr_ramp_step.sv
// ----------------------------------------------------------------------------
// spssr_ramp_step
// one ramp step of the four compare levels, staged rise or two-rate fall
// ----------------------------------------------------------------------------
module spssr_ramp_step
    import spssr_pkg::*;
(
    input  logic      i_up,
    input  t_ramp_cfg i_cfg,
    input  t_levels   i_levels,
    output t_levels   o_levels
);

    function automatic logic [LEVEL_W-1:0] inc_sat(input logic [LEVEL_W-1:0] v);
        return (v < LEVEL_MAX) ? v + 1'b1 : v;
    endfunction

    logic [LEVEL_W-1:0] step_ext;
    t_levels            up_lv;
    t_levels            dn_lv;

    assign step_ext = {{(LEVEL_W-STEP_W){1'b0}}, i_cfg.fast_step};

    // staged rise: each test sees the levels already raised in this step
    always_comb begin
        up_lv = i_levels;
        if (i_levels[1] < LEVEL_MAX) begin
            up_lv[1] = i_levels[1] + 1'b1;
            up_lv[2] = inc_sat(i_levels[2]);
        end
        if (up_lv[1] > i_cfg.stage_threshold) begin
            up_lv[3] = inc_sat(i_levels[3]);
        end
        if (up_lv[3] > i_cfg.stage_threshold) begin
            up_lv[0] = inc_sat(i_levels[0]);
        end
    end

    // fall: fast step at high levels, single step below the floor
    always_comb begin
        for (int i = 0; i < CH_COUNT; i++) begin
            if (i_levels[i] >= i_cfg.fast_floor) begin
                dn_lv[i] = (i_levels[i] > step_ext) ? i_levels[i] - step_ext : '0;
            end else if (i_levels[i] != '0) begin
                dn_lv[i] = i_levels[i] - 1'b1;
            end else begin
                dn_lv[i] = i_levels[i];
            end
        end
    end

    assign o_levels = i_up ? up_lv : dn_lv;

endmodule

// File: rtl/staged_pwm_soft_start_ramp_unit.sv
// ----------------------------------------------------------------------------
// staged_pwm_soft_start_ramp_unit
// an accepted item is held in the input register, then its result word in the result register
// throughput: one item per cycle while the result side takes words, set by the single state update stage
// reset (synchronous, active low): levels 144, ramp down, tick count zero,
// registers at their default values, both pipeline stages empty
// ----------------------------------------------------------------------------
module staged_pwm_soft_start_ramp_unit
    import spssr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    spssr_in_if.sink    i_in,
    spssr_out_if.source o_out,
    spssr_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [COUNT_W-1:0] r_tick_limit;
    t_ramp_cfg          r_ramp_cfg;

    // ramp state
    logic [COUNT_W-1:0] r_tick_count, n_tick_count;
    logic               r_up_mode, n_up_mode;
    t_levels            r_levels, n_levels;
    t_levels            step_levels;

    // input register
    logic               r_in_valid;
    logic               r_in_cmd;
    logic [7:0]         r_in_dir;

    // result register
    logic               r_out_valid;
    t_levels            r_out_levels;
    logic               r_out_stepped;
    logic               r_out_up;

    logic               advance;
    logic               n_stepped;
    logic [COUNT_W-1:0] count_inc;

    // the result register frees when empty or taken; the input register
    // moves on whenever the result register can take its word
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_limit               <= TICK_LIMIT_RST;
            r_ramp_cfg.stage_threshold <= STAGE_THRESHOLD_RST;
            r_ramp_cfg.fast_floor      <= FAST_FLOOR_RST;
            r_ramp_cfg.fast_step       <= FAST_STEP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TICK_LIMIT:      r_tick_limit <= i_cfg.data;
                CFG_STAGE_THRESHOLD: r_ramp_cfg.stage_threshold <= i_cfg.data[LEVEL_W-1:0];
                CFG_FAST_FLOOR:      r_ramp_cfg.fast_floor <= i_cfg.data[LEVEL_W-1:0];
                CFG_FAST_STEP:       r_ramp_cfg.fast_step <= i_cfg.data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd <= i_in.cmd;
            r_in_dir <= i_in.dir_byte;
        end
    end

    spssr_ramp_step u_ramp_step (
        .i_up     (r_up_mode),
        .i_cfg    (r_ramp_cfg),
        .i_levels (r_levels),
        .o_levels (step_levels)
    );

    // state update for the item held in the input register
    assign count_inc = r_tick_count + 1'b1;

    always_comb begin
        n_tick_count = r_tick_count;
        n_up_mode    = r_up_mode;
        n_levels     = r_levels;
        n_stepped    = 1'b0;
        if (r_in_cmd == CMD_DIR) begin
            // direction word: any nonzero byte means ramp up
            n_up_mode = (r_in_dir != '0);
        end else if (count_inc > r_tick_limit) begin
            // tick past the limit: clear the count and take one step
            n_tick_count = '0;
            n_levels     = step_levels;
            n_stepped    = 1'b1;
        end else begin
            n_tick_count = count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_up_mode    <= 1'b0;
            r_levels     <= {CH_COUNT{LEVEL_RST}};
        end else if (r_in_valid && advance) begin
            r_tick_count <= n_tick_count;
            r_up_mode    <= n_up_mode;
            r_levels     <= n_levels;
        end
    end

    // result register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out_levels  <= n_levels;
            r_out_stepped <= n_stepped;
            r_out_up      <= n_up_mode;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.level_ch0 = r_out_levels[0];
    assign o_out.level_ch1 = r_out_levels[1];
    assign o_out.level_ch2 = r_out_levels[2];
    assign o_out.level_ch3 = r_out_levels[3];
    assign o_out.stepped   = r_out_stepped;
    assign o_out.ramp_up   = r_out_up;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the staged soft-start ramp unit: a behavioural
// ramp predictor follows every accepted input word and each result word is
// compared field by field with the oldest prediction, under random idling
// on both channels, a long output hold-off and several register settings
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spssr_pkg::*;

    localparam int SIM_LIMIT_NS  = 5_000_000;
    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_CYCLES  = 4;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS   = 115;
    localparam int PRESSURE_WORDS = 32;

    // one result word as the bench predicts it
    typedef struct packed {
        t_levels lv;
        logic    stepped;
        logic    ramp_up;
    } t_ramp_word;

    logic i_clk;
    logic i_rst_n;

    spssr_in_if  in_ch ();
    spssr_out_if out_ch ();
    spssr_cfg_if cfg_ch ();

    staged_pwm_soft_start_ramp_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predicted words waiting for their result, oldest first
    t_ramp_word ramp_words_due[$];

    // shadow copy of the registers and the ramp state
    logic [COUNT_W-1:0] tick_limit_q;
    logic [LEVEL_W-1:0] threshold_q;
    logic [LEVEL_W-1:0] floor_q;
    logic [STEP_W-1:0]  fstep_q;
    logic [COUNT_W-1:0] ticks_q;
    logic               dir_up_q;
    t_levels            levels_q;

    int unsigned failure_count = 0;
    bit          no_idle = 1'b0;   // both sides run flat out while set
    bit          hold_req = 1'b0;  // asks the result side for a long hold-off

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // mostly back to back, some short gaps, the odd long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LEVEL_W-1:0] level_plus_one(input logic [LEVEL_W-1:0] v);
        return (v != LEVEL_MAX) ? v + 1'b1 : v;
    endfunction

    // down step: fast at or above the floor, saturating at zero; single count below
    function automatic logic [LEVEL_W-1:0] level_after_down_step(input logic [LEVEL_W-1:0] v);
        if (v >= floor_q)
            return (v > fstep_q) ? v - fstep_q : '0;
        if (v != '0)
            return v - 1'b1;
        return v;
    endfunction

    // advance the shadow state by one accepted word and queue its result
    task automatic predict_ramp_word(input logic c, input logic [7:0] d);
        t_ramp_word w;
        w.stepped = 1'b0;
        if (c == CMD_DIR) begin
            dir_up_q = (d != 8'h00);
        end else begin
            ticks_q = ticks_q + 1'b1;
            if (ticks_q > tick_limit_q) begin
                ticks_q = '0;
                w.stepped = 1'b1;
                if (dir_up_q) begin
                    // leading pair first, then each later stage sees the fresh levels
                    if (levels_q[1] != LEVEL_MAX) begin
                        levels_q[1] = level_plus_one(levels_q[1]);
                        levels_q[2] = level_plus_one(levels_q[2]);
                    end
                    if (levels_q[1] > threshold_q)
                        levels_q[3] = level_plus_one(levels_q[3]);
                    if (levels_q[3] > threshold_q)
                        levels_q[0] = level_plus_one(levels_q[0]);
                end else begin
                    for (int i = 0; i < CH_COUNT; i++)
                        levels_q[i] = level_after_down_step(levels_q[i]);
                end
            end
        end
        w.lv      = levels_q;
        w.ramp_up = dir_up_q;
        ramp_words_due.push_back(w);
    endtask

    // offer one input word after a random gap and wait for it to be taken;
    // valid is left high so a following word can go straight out
    task automatic send_word(input logic c, input logic [7:0] d);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid    <= 1'b0;
            in_ch.cmd      <= 1'($urandom);
            in_ch.dir_byte <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.cmd      <= c;
        in_ch.dir_byte <= d;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_ramp_word(c, d);
    endtask

    // mostly ticks, with direction changes now and then so ramps run long
    task automatic send_random_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 90)
            send_word(CMD_TICK, 8'($urandom));
        else if (r < 94)
            send_word(CMD_DIR, 8'h00);
        else
            send_word(CMD_DIR, 8'($urandom_range(1, 255)));
    endtask

    // stop offering and let every outstanding word come back
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (ramp_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write; only called with the unit idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_TICK_LIMIT:      tick_limit_q = data;
            CFG_STAGE_THRESHOLD: threshold_q  = data[LEVEL_W-1:0];
            CFG_FAST_FLOOR:      floor_q      = data[LEVEL_W-1:0];
            CFG_FAST_STEP:       fstep_q      = data[STEP_W-1:0];
            default: ;  // unknown index is dropped by the unit
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------

    // defaults straight out of reset: down, levels 144, a lone tick never steps
    task automatic test_reset_defaults();
        send_word(CMD_DIR, 8'h00);
        send_word(CMD_TICK, 8'hff);
    endtask

    // any nonzero byte means up, only zero means down
    task automatic test_direction_bytes();
        send_word(CMD_DIR, 8'h01);
        send_word(CMD_DIR, 8'h80);
        send_word(CMD_DIR, 8'hff);
        send_word(CMD_DIR, 8'h00);
    endtask

    // limit of zero: every tick steps, first up through the stages then down
    task automatic test_every_tick_steps();
        settle();
        write_reg(CFG_TICK_LIMIT, 16'h0000);
        write_reg(CFG_STAGE_THRESHOLD, 16'h008f);
        send_word(CMD_DIR, 8'h01);
        repeat (3) send_word(CMD_TICK, 8'h00);
        send_word(CMD_DIR, 8'h00);
        repeat (2) send_word(CMD_TICK, 8'h5a);
    endtask

    // top limit never steps; dropping it below the count steps on the next tick
    task automatic test_limit_lowered();
        settle();
        write_reg(CFG_TICK_LIMIT, 16'hffff);
        repeat (3) send_word(CMD_TICK, 8'h00);
        settle();
        write_reg(CFG_TICK_LIMIT, 16'h0001);
        send_word(CMD_TICK, 8'h00);
    endtask

    // zero fast step, widest fast step, floor of zero and the highest floor
    task automatic test_fast_step_edges();
        settle();
        write_reg(CFG_TICK_LIMIT, 16'h0000);
        write_reg(CFG_FAST_FLOOR, 16'h0000);
        write_reg(CFG_FAST_STEP, 16'hffe0);     // upper bits dropped, step of zero
        send_word(CMD_TICK, 8'h00);
        settle();
        write_reg(CFG_FAST_STEP, 16'h001f);
        send_word(CMD_TICK, 8'h00);
        settle();
        write_reg(CFG_FAST_FLOOR, 16'habff);
        write_reg(CFG_FAST_STEP, 16'd16);
        send_word(CMD_TICK, 8'h00);
    endtask

    // writes to indexes past the last register change nothing
    task automatic test_ignored_indexes();
        settle();
        write_reg(8'd4, 16'h0000);
        write_reg(8'hff, 16'hffff);
        repeat (2) send_word(CMD_TICK, 8'h00);
    endtask

    // result side holds off for a long stretch while words keep coming,
    // so the pipeline fills and the input side has to stall
    task automatic test_output_backpressure();
        settle();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (PRESSURE_WORDS) send_random_word();
        settle();
        no_idle = 1'b0;
    endtask

    // random words under several register settings, extremes among them
    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] lim;
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] flr;
        logic [CFG_DATA_W-1:0] stp;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            // short limits keep the ramp moving; the odd longer one as well
            if (p == 0)
                lim = 16'h0000;
            else if ($urandom_range(0, 9) == 0)
                lim = 16'($urandom_range(4, 40));
            else
                lim = 16'($urandom_range(0, 3));
            thr = (p == 1) ? 16'h00ff : (p == 2) ? 16'h0000 : 16'($urandom);
            flr = (p == 3) ? 16'h0001 : (p == 4) ? 16'h00ff : 16'($urandom);
            stp = (p == 5) ? 16'd16 : 16'($urandom);
            write_reg(CFG_TICK_LIMIT, lim);
            write_reg(CFG_STAGE_THRESHOLD, thr);
            write_reg(CFG_FAST_FLOOR, flr);
            write_reg(CFG_FAST_STEP, stp);
            no_idle = (p == 2);     // one phase with no gaps on either side
            repeat (PHASE_WORDS) send_random_word();
        end
        settle();
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side: random ready, plus the long hold-off when asked
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left   = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = no_idle ? 0 : pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: each taken word against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_words
        t_ramp_word due;
        t_ramp_word got;
        logic       bad;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.lv[0]   = out_ch.level_ch0;
            got.lv[1]   = out_ch.level_ch1;
            got.lv[2]   = out_ch.level_ch2;
            got.lv[3]   = out_ch.level_ch3;
            got.stepped = out_ch.stepped;
            got.ramp_up = out_ch.ramp_up;
            if (ramp_words_due.size() == 0) begin
                failure_count++;
                if (failure_count <= MAX_REPORTS)
                    $display("%0t: result word with none predicted: ch %0d %0d %0d %0d step %0b up %0b",
                             $realtime, got.lv[0], got.lv[1], got.lv[2], got.lv[3],
                             got.stepped, got.ramp_up);
            end else begin
                due = ramp_words_due.pop_front();
                bad = 1'b0;
                for (int i = 0; i < CH_COUNT; i++)
                    if (got.lv[i] !== due.lv[i]) bad = 1'b1;
                if (got.stepped !== due.stepped) bad = 1'b1;
                if (got.ramp_up !== due.ramp_up) bad = 1'b1;
                if (bad) begin
                    failure_count++;
                    if (failure_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch, expected ch %0d %0d %0d %0d step %0b up %0b",
                                 $realtime, due.lv[0], due.lv[1], due.lv[2], due.lv[3],
                                 due.stepped, due.ramp_up);
                        $display("%0t: mismatch, got ch %0d %0d %0d %0d step %0b up %0b",
                                 $realtime, got.lv[0], got.lv[1], got.lv[2], got.lv[3],
                                 got.stepped, got.ramp_up);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        // every input known from time zero, reset held low
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.cmd      = CMD_TICK;
        in_ch.dir_byte = 8'h00;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_TICK_LIMIT;
        cfg_ch.data    = '0;

        // shadow state matches the unit after reset
        tick_limit_q = TICK_LIMIT_RST;
        threshold_q  = STAGE_THRESHOLD_RST;
        floor_q      = FAST_FLOOR_RST;
        fstep_q      = FAST_STEP_RST;
        ticks_q      = '0;
        dir_up_q     = 1'b0;
        for (int i = 0; i < CH_COUNT; i++)
            levels_q[i] = LEVEL_RST;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_direction_bytes();
        test_every_tick_steps();
        test_limit_lowered();
        test_fast_step_edges();
        test_ignored_indexes();
        test_output_backpressure();
        test_random_phases();

        // everything back, then a further wait for any stray word
        settle();
        repeat (8) @(posedge i_clk);
        if (failure_count == 0)
            $display("staged_pwm_soft_start_ramp_unit verification clean");
        else
            $display("staged_pwm_soft_start_ramp_unit verification failed");
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial begin
        #(SIM_LIMIT_NS * 1ns);
        $display("staged_pwm_soft_start_ramp_unit verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/spssr_pkg.sv
rtl/spssr_if.sv
rtl/spssr_ramp_step.sv
rtl/staged_pwm_soft_start_ramp_unit.sv
tb/testbench.sv
